// ===== hdl/priority_job_queue_with_merge_evict_core_assert.svh =====
// Assertion macros for the job queue checker.
`ifndef PRIORITY_JOB_QUEUE_WITH_MERGE_EVICT_CORE_ASSERT_SVH
`define PRIORITY_JOB_QUEUE_WITH_MERGE_EVICT_CORE_ASSERT_SVH

`define PJQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define PJQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pjq_pkg.sv =====
`timescale 1ns / 1ps
package pjq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TagBits    = 16;
  localparam int unsigned IdxW       = $clog2(QueueDepth + 1);
  localparam int unsigned PosW       = $clog2(QueueDepth);

  localparam logic [1:0] OpEnq    = 2'd0;
  localparam logic [1:0] OpDone   = 2'd1;
  localparam logic [1:0] OpSelect = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  localparam logic [1:0] KindOpen = 2'd0;
  localparam logic [1:0] PrioSel  = 2'd2;

  localparam int unsigned InW  = 72;
  localparam int unsigned OutW = 56;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  prio;
    logic [16:0] frame;
    logic [15:0] ticket;
    logic [31:0] reserve;
  } entry_t;

  // shift-chain command to every cell
  typedef struct packed {
    logic         load;     // write tail cell
    logic         remove;   // close gap at pos
    logic [PosW-1:0] pos;
    logic [IdxW-1:0] count;
  } chain_cmd_t;

  // per-cell match flags reported back to the controller
  typedef struct packed {
    logic valid;
    logic merge;
    logic lower;
  } cell_flag_t;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StScan  = 6'b000010,
    StEmit  = 6'b000100,
    StPick  = 6'b001000,
    StSlot  = 6'b010000,
    StOut   = 6'b100000
  } state_e;

endpackage

// ===== hdl/priority_job_queue_with_merge_evict_core.sv =====
`timescale 1ns / 1ps
// Request queue with one execution slot, kept in arrival order in a row of cells.
// s_axis: one command beat per input; tdata from bit 0 up: opcode, ticket_tag,
//   job_kind, priority_req, has_frame, frame_index, reservation, one pad bit.
// m_axis: one beat per cancel or dispatch; tdata from bit 0 up: event_res,
//   out_ticket, out_kind, out_reservation, pad. tlast marks the final beat an
//   input causes. An input that causes no result emits nothing.
// cfg: write reservation_budget when cfg_valid_i and cfg_ready_o are high (idle only).
// One input is worked at a time; s_axis_tready is high only when idle.
// Steps from accept to next accept: decode, close and accept; an emit step per cancel
//   beat; a slot check after a push or a completion; and for a dispatch a priority
//   search over every queued entry (1 to 16) plus a step to register the beat.
// Reset empties the queue and slot, clears the target flag and loads the
// default budget. A stalled m_axis receiver holds the output beat and the next
// beat waits in the controller; nothing is dropped.
module priority_job_queue_with_merge_evict_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // opcode, ticket_tag, job_kind, priority_req, has_frame, frame_index, reservation, pad
  input  logic [pjq_pkg::InW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // event_res, out_ticket, out_kind, out_reservation, pad
  output logic [pjq_pkg::OutW-1:0] m_axis_tdata,
  output logic                     m_axis_tlast,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [31:0]              cfg_data_i
);

  localparam int unsigned N = pjq_pkg::QueueDepth;
  localparam int unsigned PW = pjq_pkg::PosW;
  localparam int unsigned IW = pjq_pkg::IdxW;

  pjq_pkg::state_e st_q;
  logic [31:0] budget_q;
  logic [1:0]  op_q;
  pjq_pkg::entry_t req_q;
  logic        tgt_q, busy_q, push_q, merged_q, full_done_q;
  pjq_pkg::entry_t slot_q;
  logic [IW-1:0] count_q, count_d;
  logic [PW-1:0] best_q, scan_q;
  logic [1:0]  bestp_q;

  // pending emit
  logic        ev_q;
  pjq_pkg::entry_t em_q;
  logic        em_rm_q;
  logic [PW-1:0] em_pos_q;
  logic        em_slot_q, em_last_q;
  logic        ov_q, olast_q;
  logic [pjq_pkg::OutW-1:0] odata_q;

  pjq_pkg::chain_cmd_t cmd;
  pjq_pkg::entry_t ents [N];
  pjq_pkg::cell_flag_t flags [N];
  pjq_pkg::entry_t zero_e;

  assign zero_e = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    pjq_cell u_cell (
      .clk_i, .rst_ni,
      .my_pos_i   (PW'(g)),
      .cmd_i      (cmd),
      .new_i      (req_q),
      .next_i     ((g + 1 < N) ? ents[(g + 1) % N] : zero_e),
      .req_kind_i (req_q.kind),
      .req_frame_i(req_q.frame),
      .req_prio_i (req_q.prio),
      .ent_o      (ents[g]),
      .flag_o     (flags[g])
    );
  end

  logic merge_hit, lower_hit;
  logic [PW-1:0] merge_pos, lower_pos;
  always_comb begin
    merge_hit = 1'b0;
    lower_hit = 1'b0;
    merge_pos = '0;
    lower_pos = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (flags[i].merge) begin
        merge_hit = 1'b1;
        merge_pos = PW'(i);
      end
      if (flags[i].lower) begin
        lower_hit = 1'b1;
        lower_pos = PW'(i);
      end
    end
  end

  logic in_fire, out_free;
  assign s_axis_tready = st_q == pjq_pkg::StIdle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = st_q == pjq_pkg::StIdle;
  assign out_free      = !ov_q || m_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  logic emit_go;
  logic rej;
  logic [PW-1:0] evict_pos;
  logic          scan_take, scan_end;
  logic [PW-1:0] scan_pick;

  assign rej = (!tgt_q && req_q.kind != pjq_pkg::KindOpen) || req_q.reserve > budget_q;
  assign evict_pos = lower_hit ? lower_pos : '0;
  assign scan_take = scan_q == '0 || ents[scan_q].prio > bestp_q;
  assign scan_pick = scan_take ? scan_q : best_q;
  assign scan_end  = ({1'b0, scan_q} + 1'b1) >= count_q;

  always_comb begin
    count_d    = count_q;
    cmd.load   = 1'b0;
    cmd.remove = 1'b0;
    cmd.pos    = em_pos_q;
    cmd.count  = count_q;
    emit_go    = 1'b0;
    case (st_q)
      pjq_pkg::StEmit: begin
        if (out_free) begin
          emit_go = 1'b1;
          cmd.remove = em_rm_q;
          if (em_rm_q) count_d = count_q - 1'b1;
        end
      end
      pjq_pkg::StPick: begin
        if (push_q) begin
          cmd.load = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pjq_pkg::StIdle;
      budget_q <= 32'd67108864;
      op_q <= '0;
      req_q <= '0;
      tgt_q <= 1'b0;
      busy_q <= 1'b0;
      push_q <= 1'b0;
      merged_q <= 1'b0;
      full_done_q <= 1'b0;
      slot_q <= '0;
      count_q <= '0;
      best_q <= '0;
      scan_q <= '0;
      bestp_q <= '0;
      ev_q <= 1'b0;
      em_q <= '0;
      em_rm_q <= 1'b0;
      em_pos_q <= '0;
      em_slot_q <= 1'b0;
      em_last_q <= 1'b0;
      ov_q <= 1'b0;
      olast_q <= 1'b0;
      odata_q <= '0;
    end else begin
      count_q <= count_d;
      ov_q <= emit_go || (ov_q && !m_axis_tready);
      if (cfg_valid_i && cfg_ready_o) budget_q <= cfg_data_i;
      if (emit_go) begin
        olast_q <= em_last_q;
        odata_q <= {5'd0, em_q.reserve, em_q.kind, em_q.ticket, ev_q};
      end
      case (st_q)
        pjq_pkg::StIdle: begin
          if (in_fire) begin
            op_q <= s_axis_tdata[1:0];
            req_q.ticket  <= s_axis_tdata[2 +: 16] & 16'((64'd1 << pjq_pkg::TagBits) - 1);
            req_q.kind    <= s_axis_tdata[18 +: 2];
            req_q.prio    <= s_axis_tdata[20 +: 2];
            req_q.frame   <= {s_axis_tdata[22], s_axis_tdata[23 +: 16]};
            req_q.reserve <= s_axis_tdata[39 +: 32];
            merged_q <= 1'b0;
            full_done_q <= 1'b0;
            push_q <= 1'b1;
            st_q <= pjq_pkg::StScan;
          end
        end
        pjq_pkg::StScan: begin
          // decide the next result of this command
          if (op_q == pjq_pkg::OpEnq) begin
            if (!merged_q && rej) begin
              ev_q <= 1'b0; em_q <= req_q; em_rm_q <= 1'b0;
              em_slot_q <= 1'b0; em_last_q <= 1'b1;
              push_q <= 1'b0; merged_q <= 1'b1; full_done_q <= 1'b1;
              st_q <= pjq_pkg::StEmit;
            end else if (!merged_q && merge_hit) begin
              merged_q <= 1'b1;
              ev_q <= 1'b0; em_q <= ents[merge_pos]; em_rm_q <= 1'b1;
              em_pos_q <= merge_pos; em_slot_q <= 1'b0; em_last_q <= busy_q;
              st_q <= pjq_pkg::StEmit;
            end else if (!full_done_q && count_q >= IW'(N)) begin
              merged_q <= 1'b1; full_done_q <= 1'b1;
              ev_q <= 1'b0; em_slot_q <= 1'b0;
              if (lower_hit || req_q.prio == pjq_pkg::PrioSel) begin
                em_rm_q <= 1'b1;
                em_pos_q <= evict_pos;
                em_q <= ents[evict_pos];
                em_last_q <= busy_q;
              end else begin
                em_q <= req_q; em_rm_q <= 1'b0; em_last_q <= 1'b1; push_q <= 1'b0;
              end
              st_q <= pjq_pkg::StEmit;
            end else begin
              merged_q <= 1'b1; full_done_q <= 1'b1;
              st_q <= push_q ? pjq_pkg::StPick : pjq_pkg::StOut;
            end
          end else if (op_q == pjq_pkg::OpDone) begin
            if (busy_q && slot_q.ticket == req_q.ticket) busy_q <= 1'b0;
            push_q <= 1'b0;
            st_q <= pjq_pkg::StPick;
          end else begin
            if (count_q != '0) begin
              ev_q <= 1'b0; em_q <= ents[0]; em_rm_q <= 1'b1; em_pos_q <= '0;
              em_slot_q <= 1'b0; em_last_q <= count_q == IW'(1) && !busy_q;
              st_q <= pjq_pkg::StEmit;
            end else if (busy_q) begin
              ev_q <= 1'b0; em_q <= slot_q; em_rm_q <= 1'b0;
              em_slot_q <= 1'b1; em_last_q <= 1'b1;
              st_q <= pjq_pkg::StEmit;
            end else begin
              tgt_q <= op_q == pjq_pkg::OpSelect;
              st_q <= pjq_pkg::StOut;
            end
          end
        end
        pjq_pkg::StEmit: begin
          if (out_free) begin
            if (em_slot_q) busy_q <= 1'b0;
            st_q <= (ev_q) ? pjq_pkg::StOut : pjq_pkg::StScan;
          end
        end
        pjq_pkg::StPick: begin
          // start priority search over the chain
          scan_q <= '0;
          best_q <= '0;
          bestp_q <= 2'd0;
          if (!busy_q && count_d != '0) st_q <= pjq_pkg::StSlot;
          else st_q <= pjq_pkg::StOut;
        end
        pjq_pkg::StSlot: begin
          if (scan_end) begin
            ev_q <= 1'b1; em_q <= ents[scan_pick]; em_pos_q <= scan_pick;
            em_rm_q <= 1'b1; em_slot_q <= 1'b0; em_last_q <= 1'b1;
            busy_q <= 1'b1;
            slot_q <= ents[scan_pick];
            st_q <= pjq_pkg::StEmit;
          end else begin
            if (scan_take) begin
              best_q <= scan_q;
              bestp_q <= ents[scan_q].prio;
            end
            scan_q <= scan_q + 1'b1;
          end
        end
        pjq_pkg::StOut: begin
          st_q <= pjq_pkg::StIdle;
        end
        default: st_q <= pjq_pkg::StIdle;
      endcase
    end
  end

endmodule

// ===== hdl/pjq_cell.sv =====
`timescale 1ns / 1ps
module pjq_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pjq_pkg::PosW-1:0] my_pos_i,
  input  pjq_pkg::chain_cmd_t      cmd_i,
  input  pjq_pkg::entry_t          new_i,
  input  pjq_pkg::entry_t          next_i,
  input  logic [1:0]               req_kind_i,
  input  logic [16:0]              req_frame_i,
  input  logic [1:0]               req_prio_i,
  output pjq_pkg::entry_t          ent_o,
  output pjq_pkg::cell_flag_t      flag_o
);

  pjq_pkg::entry_t ent_q, ent_d;
  logic [pjq_pkg::IdxW-1:0] me;

  assign me = {1'b0, my_pos_i};

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.load && me == cmd_i.count) begin
      ent_d = new_i;
    end else if (cmd_i.remove && my_pos_i >= cmd_i.pos && me + 1'b1 < cmd_i.count) begin
      ent_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o        = ent_q;
  assign flag_o.valid = me < cmd_i.count;
  assign flag_o.merge = flag_o.valid && req_frame_i[16] && ent_q.kind == req_kind_i
                        && ent_q.frame == req_frame_i;
  assign flag_o.lower = flag_o.valid && ent_q.prio < req_prio_i;

endmodule

// ===== hdl/pjq_checker.sv =====
`timescale 1ns / 1ps
`include "priority_job_queue_with_merge_evict_core_assert.svh"
module pjq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `PJQ_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat dropped while stalled")
  `PJQ_ASSERT_IMPL(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[55:51] == 5'd0, "pad bits set")
  `PJQ_ASSERT_NEXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second input taken at once")
endmodule

bind priority_job_queue_with_merge_evict_core pjq_checker u_pjq_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned Depth = pjq_pkg::QueueDepth;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 60;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] tag;
    logic [1:0]  kind;
    logic [1:0]  prio;
    logic        has_frame;
    logic [15:0] frame;
    logic [31:0] resv;
  } job_req_t;

  typedef struct {
    logic        dispatched;
    logic [15:0] ticket;
    logic [1:0]  kind;
    logic [31:0] resv;
    logic        last;
  } job_event_t;

  typedef struct {
    job_req_t   req;
    bit         typed;
    job_event_t ev;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  priority_job_queue_with_merge_evict_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),  // opcode, ticket_tag, job_kind, priority_req, has_frame,
                                   // frame_index, reservation, pad
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),  // event_res, out_ticket, out_kind, out_reservation, pad
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // queue model
  logic [1:0]  q_kind [Depth];
  logic [1:0]  q_prio [Depth];
  logic [16:0] q_frame[Depth];
  logic [15:0] q_tag  [Depth];
  logic [31:0] q_resv [Depth];
  int unsigned q_len;
  logic        busy;
  logic [15:0] busy_tag;
  logic [1:0]  busy_kind;
  logic [31:0] busy_resv;
  logic        has_target;
  logic [31:0] budget;

  job_event_t pending_events[$];
  table_row_t directed[$];
  int unsigned errors, n_sent, n_events, n_dispatch, n_cancel, n_full;
  int unsigned quiet_cycles;
  bit          rx_idle_on, tx_idle_on;
  int unsigned rx_stall;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void push_event(input logic d, input logic [15:0] t,
                                     input logic [1:0] k, input logic [31:0] r);
    job_event_t e;
    e.dispatched = d;
    e.ticket = t;
    e.kind = k;
    e.resv = r;
    e.last = 1'b0;
    pending_events.insert(pending_events.size(), e);
  endfunction

  function automatic void drop_entry(input int unsigned pos, input bit cancel);
    if (cancel) push_event(1'b0, q_tag[pos], q_kind[pos], q_resv[pos]);
    for (int unsigned i = pos; i + 1 < q_len; i++) begin
      q_kind[i] = q_kind[i + 1];
      q_prio[i] = q_prio[i + 1];
      q_frame[i] = q_frame[i + 1];
      q_tag[i] = q_tag[i + 1];
      q_resv[i] = q_resv[i + 1];
    end
    q_len--;
  endfunction

  function automatic void dispatch_next();
    int unsigned top;
    top = 0;
    if (busy || q_len == 0) return;
    for (int unsigned i = 1; i < q_len; i++)
      if (q_prio[i] > q_prio[top]) top = i;
    busy = 1'b1;
    busy_tag = q_tag[top];
    busy_kind = q_kind[top];
    busy_resv = q_resv[top];
    push_event(1'b1, busy_tag, busy_kind, busy_resv);
    drop_entry(top, 1'b0);
  endfunction

  // returns the number of events this request adds
  function automatic int unsigned predict_events(input job_req_t r);
    int unsigned before_len, victim;
    logic [16:0] fr;
    bit          keep;
    before_len = pending_events.size();
    fr = {r.has_frame, r.frame};
    if (r.op == pjq_pkg::OpEnq) begin
      if ((!has_target && r.kind != pjq_pkg::KindOpen) || r.resv > budget) begin
        push_event(1'b0, r.tag, r.kind, r.resv);
      end else begin
        keep = 1'b1;
        if (r.has_frame) begin
          for (int unsigned i = 0; i < q_len; i++) begin
            if (q_kind[i] == r.kind && q_frame[i] == fr) begin
              drop_entry(i, 1'b1);
              break;
            end
          end
        end
        if (q_len >= Depth) begin
          n_full++;
          victim = q_len;
          for (int unsigned i = 0; i < q_len; i++) begin
            if (q_prio[i] < r.prio) begin
              victim = i;
              break;
            end
          end
          if (victim == q_len && r.prio != pjq_pkg::PrioSel) begin
            push_event(1'b0, r.tag, r.kind, r.resv);
            keep = 1'b0;
          end else begin
            if (victim == q_len) victim = 0;
            drop_entry(victim, 1'b1);
          end
        end
        if (keep && q_len < Depth) begin
          q_kind[q_len] = r.kind;
          q_prio[q_len] = r.prio;
          q_frame[q_len] = fr;
          q_tag[q_len] = r.tag;
          q_resv[q_len] = r.resv;
          q_len++;
          dispatch_next();
        end
      end
    end else if (r.op == pjq_pkg::OpDone) begin
      if (busy && busy_tag == r.tag) busy = 1'b0;
      dispatch_next();
    end else begin
      while (q_len > 0) drop_entry(0, 1'b1);
      if (busy) begin
        push_event(1'b0, busy_tag, busy_kind, busy_resv);
        busy = 1'b0;
      end
      has_target = (r.op == pjq_pkg::OpSelect);
    end
    if (pending_events.size() > before_len)
      pending_events[pending_events.size() - 1].last = 1'b1;
    return pending_events.size() - before_len;
  endfunction

  task automatic send_request(input job_req_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, r.resv, r.frame, r.has_frame, r.prio, r.kind, r.tag, r.op};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic sender_gap();
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic write_budget(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    budget = value;
  endtask

  function automatic logic [31:0] pick_resv();
    logic [63:0] span;
    span = 64'(budget) + 1;
    case ($urandom_range(0, 9))
      0: return budget;
      1: return budget + 32'd1;
      2: return $urandom;
      3: return 32'd0;
      default: return 32'($urandom % span);
    endcase
  endfunction

  function automatic job_req_t random_request();
    job_req_t r;
    int unsigned pick;
    r.tag = 16'($urandom);
    r.kind = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    r.prio = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    r.has_frame = ($urandom_range(0, 3) != 0);
    r.frame = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    r.resv = pick_resv();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      r.op = pjq_pkg::OpEnq;
    end else if (pick < 90) begin
      r.op = pjq_pkg::OpDone;
      if (busy && $urandom_range(0, 4) != 0) r.tag = busy_tag;
    end else if (pick < 97) begin
      r.op = pjq_pkg::OpSelect;
    end else begin
      r.op = pjq_pkg::OpClear;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_stall <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    job_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_events++;
      if (pending_events.size() == 0) begin
        report($sformatf("unexpected beat %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_events.pop_front();
        if (want.dispatched) n_dispatch++;
        else n_cancel++;
        if (m_axis_tdata[0] !== want.dispatched)
          report($sformatf("event_res %b want %b", m_axis_tdata[0], want.dispatched));
        if (m_axis_tdata[16:1] !== want.ticket)
          report($sformatf("ticket %h want %h", m_axis_tdata[16:1], want.ticket));
        if (m_axis_tdata[18:17] !== want.kind)
          report($sformatf("kind %0d want %0d", m_axis_tdata[18:17], want.kind));
        if (m_axis_tdata[50:19] !== want.resv)
          report($sformatf("reservation %h want %h", m_axis_tdata[50:19], want.resv));
        if (m_axis_tlast !== want.last)
          report($sformatf("tlast %b want %b", m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_row(input logic [1:0] op, input logic [15:0] tag,
                                  input logic [1:0] kind, input logic [1:0] prio,
                                  input logic hf, input logic [15:0] fr,
                                  input logic [31:0] resv, input bit typed);
    table_row_t t;
    t.req = '{op, tag, kind, prio, hf, fr, resv};
    t.typed = typed;
    t.ev = '{1'b0, tag, kind, resv, 1'b1};
    directed.insert(directed.size(), t);
  endfunction

  initial begin
    logic [31:0] budgets[5];
    job_req_t    r;
    int unsigned got, guard;

    q_len = 0;
    busy = 1'b0;
    busy_tag = '0;
    busy_kind = '0;
    busy_resv = '0;
    has_target = 1'b0;
    budget = 32'd67108864;
    rx_stall = 0;
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;

    add_row(pjq_pkg::OpEnq,    16'h0001, 2'd1, 2'd0, 1'b0, 16'h0000, 32'd0, 1'b1);
    add_row(pjq_pkg::OpEnq,    16'h0002, 2'd0, 2'd0, 1'b0, 16'h0000, '1, 1'b1);
    add_row(pjq_pkg::OpEnq,    16'hFFFF, 2'd0, 2'd0, 1'b1, 16'h0000, 32'd67108864, 1'b0);
    add_row(pjq_pkg::OpDone,   16'h1234, 2'd0, 2'd0, 1'b0, 16'h0000, 32'd0, 1'b0);
    add_row(pjq_pkg::OpDone,   16'hFFFF, 2'd0, 2'd0, 1'b0, 16'h0000, 32'd0, 1'b0);
    add_row(pjq_pkg::OpSelect, 16'h0000, 2'd0, 2'd0, 1'b0, 16'h0000, 32'd0, 1'b0);
    add_row(pjq_pkg::OpEnq,    16'h0010, 2'd1, 2'd1, 1'b1, 16'hFFFF, 32'd5, 1'b0);
    add_row(pjq_pkg::OpEnq,    16'h0011, 2'd1, 2'd0, 1'b1, 16'hFFFF, 32'd6, 1'b0);
    add_row(pjq_pkg::OpEnq,    16'h0012, 2'd1, 2'd2, 1'b1, 16'hFFFF, 32'd7, 1'b0);
    add_row(pjq_pkg::OpEnq,    16'h0013, 2'd2, 2'd3, 1'b0, 16'hFFFF, 32'd8, 1'b0);
    add_row(pjq_pkg::OpEnq,    16'h0014, 2'd3, 2'd2, 1'b1, 16'h0000, 32'd9, 1'b0);
    add_row(pjq_pkg::OpEnq,    16'h0015, 2'd0, 2'd0, 1'b1, 16'h8000, 32'd0, 1'b0);
    add_row(pjq_pkg::OpDone,   16'h0010, 2'd0, 2'd0, 1'b0, 16'h0000, 32'd0, 1'b0);
    add_row(pjq_pkg::OpClear,  16'h0000, 2'd0, 2'd0, 1'b0, 16'h0000, 32'd0, 1'b0);
    add_row(pjq_pkg::OpEnq,    16'h0020, 2'd2, 2'd1, 1'b0, 16'h0000, 32'd1, 1'b1);
    add_row(pjq_pkg::OpSelect, 16'h0000, 2'd0, 2'd0, 1'b0, 16'h0000, 32'd0, 1'b0);
    add_row(pjq_pkg::OpDone,   16'h0000, 2'd0, 2'd0, 1'b0, 16'h0000, 32'd0, 1'b0);

    budgets[0] = 32'd0;
    budgets[1] = 32'hFFFF_FFFF;
    budgets[2] = 32'h0000_1000;
    budgets[3] = $urandom;
    budgets[4] = 32'd67108864;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_request(directed[i].req);
      got = predict_events(directed[i].req);
      if (directed[i].typed) begin
        // typed rows cause exactly one beat: the request itself, cancelled
        if (got != 1) report($sformatf("row %0d predicts %0d beats", i, got));
        void'(pending_events.pop_back());
        pending_events.insert(pending_events.size(), directed[i].ev);
      end
      sender_gap();
    end

    foreach (budgets[p]) begin
      write_budget(budgets[p]);
      if (p == 4) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      for (int unsigned k = 0; k < 90; k++) begin
        r = random_request();
        send_request(r);
        void'(predict_events(r));
        sender_gap();
      end
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (pending_events.size() != 0 && guard < 20 * StallLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_events.size() != 0)
      report($sformatf("%0d beats never arrived", pending_events.size()));

    $display("sent %0d requests over 6 budget settings, %0d full-queue enqueues",
             n_sent, n_full);
    $display("checked %0d beats: %0d dispatched, %0d cancelled",
             n_events, n_dispatch, n_cancel);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pjq_pkg.sv
hdl/pjq_cell.sv
hdl/priority_job_queue_with_merge_evict_core.sv
hdl/pjq_checker.sv
tb/testbench.sv
